FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the halton radical inverse block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define HRI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define HRI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hri_pkg.sv
// ----------------------------------------------------------------------------
// hri_pkg
// widths, types and control structures shared by the radical inverse block
// ----------------------------------------------------------------------------
`default_nettype none

package hri_pkg;

   // field widths
   localparam int INDEX_WIDTH    = 32;
   localparam int FRACTION_WIDTH = 32;
   localparam int RADIX_WIDTH    = 8;

   // shared divider datapath spans the wider of index and fraction
   localparam int WORK_WIDTH = (INDEX_WIDTH > FRACTION_WIDTH) ? INDEX_WIDTH : FRACTION_WIDTH;
   localparam int IDX_PAD    = WORK_WIDTH - INDEX_WIDTH;
   localparam int FRAC_PAD   = WORK_WIDTH - FRACTION_WIDTH;
   localparam int STEP_W     = $clog2(WORK_WIDTH + 1);

   // a positive index has at most INDEX_WIDTH-1 digits (base two)
   localparam int DIGIT_DEPTH = INDEX_WIDTH - 1;
   localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
   localparam int COUNT_W     = $clog2(DIGIT_DEPTH + 1);

   typedef logic [INDEX_WIDTH-1:0]    index_type;
   typedef logic [FRACTION_WIDTH-1:0] fraction_type;
   typedef logic [RADIX_WIDTH-1:0]    radix_type;
   typedef logic [WORK_WIDTH-1:0]     work_type;
   typedef logic [STEP_W-1:0]         step_type;
   typedef logic [DIGIT_AW-1:0]       digit_addr_type;
   typedef logic [COUNT_W-1:0]        digit_count_type;

   // sequencer to divider
   typedef struct packed {
      logic     start;
      step_type steps;
   } div_ctrl_type;

   // divider to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: rtl/hri_stream_if.sv
// ----------------------------------------------------------------------------
// hri_stream_if
// valid/ready channels for index requests and radical inverse responses
// ----------------------------------------------------------------------------
`default_nettype none

interface hri_req_if import hri_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type sample_index;
   radix_type radix;

   modport source (output valid, output sample_index, output radix, input ready);
   modport sink   (input valid, input sample_index, input radix, output ready);
endinterface

interface hri_rsp_if import hri_pkg::*; ();
   logic         valid;
   logic         ready;
   fraction_type fraction;
   logic         bad_radix;

   modport source (output valid, output fraction, output bad_radix, input ready);
   modport sink   (input valid, input fraction, input bad_radix, output ready);
endinterface

`default_nettype wire

FILE: rtl/hri_ram.sv
// ----------------------------------------------------------------------------
// hri_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module hri_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/hri_div_unit.sv
// ----------------------------------------------------------------------------
// hri_div_unit
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hri_div_unit import hri_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctrl_type ctrl,
   input  wire radix_type    divisor,
   input  wire radix_type    rem_init,
   input  wire work_type     dvd_init,
   output div_stat_type      stat,
   output radix_type         remainder,
   output work_type          quotient
);

   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   step_type  left_ff, left_in;
   radix_type rem_ff, rem_in;
   work_type  dvd_ff, dvd_in;

   logic [RADIX_WIDTH:0] shifted;
   logic [RADIX_WIDTH:0] diff;
   logic                 fits;

   // one shift-subtract step: dividend bits leave at the top, quotient bits enter below
   always_comb begin
      shifted = {rem_ff, dvd_ff[WORK_WIDTH-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
   end

   // step control and datapath
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      left_in = left_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         left_in = ctrl.steps;
         rem_in  = rem_init;
         dvd_in  = dvd_init;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[RADIX_WIDTH-1:0] : shifted[RADIX_WIDTH-1:0];
         dvd_in  = {dvd_ff[WORK_WIDTH-2:0], fits};
         left_in = left_ff - 1'b1;
         if (left_ff == step_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;
   assign quotient  = dvd_ff;

endmodule

`default_nettype wire

FILE: rtl/halton_radical_inverse.sv
// ----------------------------------------------------------------------------
// halton_radical_inverse
// exact halton radical inverse of an index in a given base, 0.32 fraction out
// ----------------------------------------------------------------------------
//  channel    dir   fields                         handshake
//  req_chan   in    sample_index, radix            valid / ready
//  rsp_chan   out   fraction, bad_radix            valid / ready
//
//  one transaction at a time; req_chan.ready is high only while idle
//  each item runs the one-bit-per-cycle shared divider once per index digit to
//  extract it and once per digit to fold it into the fraction; a zero or negative
//  index or a bad radix skips the divider and goes straight to the result
//  the result is held in an output register until rsp_chan.ready takes it
//  reset is synchronous and returns the sequencer to idle with no result pending
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module halton_radical_inverse import hri_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   hri_req_if.sink   req_chan,
   hri_rsp_if.source rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_EXTRACT    = 6'b000010,
      ST_FETCH      = 6'b000100,
      ST_FOLD_START = 6'b001000,
      ST_FOLD       = 6'b010000,
      ST_DONE       = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   radix_type       radix_ff, radix_in;
   logic            bad_ff, bad_in;
   fraction_type    acc_ff, acc_in;
   digit_count_type count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   fraction_type    fraction_ff, fraction_in;
   logic            bad_out_ff, bad_out_in;

   div_ctrl_type dctrl;
   div_stat_type dstat;
   radix_type    div_rem_init;
   work_type     div_dvd_init;
   radix_type    div_rem;
   work_type     div_quo;
   index_type    quo_index;

   logic           wr_en;
   digit_addr_type wr_addr;
   digit_addr_type rd_addr;
   radix_type      rd_digit;

   logic load_out;

   assign quo_index = div_quo[INDEX_WIDTH-1:0];
   assign wr_addr   = digit_addr_type'(count_ff);
   assign rd_addr   = digit_addr_type'(count_ff - 1'b1);

   // shared divider
   hri_div_unit u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (dctrl),
      .divisor   (radix_ff),
      .rem_init  (div_rem_init),
      .dvd_init  (div_dvd_init),
      .stat      (dstat),
      .remainder (div_rem),
      .quotient  (div_quo)
   );

   // digit stack, least significant digit at the bottom
   hri_ram #(
      .WIDTH (RADIX_WIDTH),
      .DEPTH (DIGIT_DEPTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (div_rem),
      .rd_addr (rd_addr),
      .rd_data (rd_digit)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      dctrl.start  = 1'b0;
      dctrl.steps  = step_type'(INDEX_WIDTH);
      div_rem_init = '0;
      div_dvd_init = work_type'(req_chan.sample_index) << IDX_PAD;
      wr_en        = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               radix_in = req_chan.radix;
               bad_in   = (req_chan.radix < radix_type'(2));
               acc_in   = '0;
               count_in = '0;
               // bad radix, negative or zero index: answer is zero
               if (bad_in || req_chan.sample_index[INDEX_WIDTH-1] ||
                   (req_chan.sample_index == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  dctrl.start = 1'b1;
                  state_in    = ST_EXTRACT;
               end
            end
         end
         ST_EXTRACT: begin
            div_dvd_init = work_type'(quo_index) << IDX_PAD;
            if (dstat.done) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (quo_index == '0) begin
                  state_in = ST_FETCH;
               end else begin
                  dctrl.start = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_FOLD_START;
         end
         ST_FOLD_START: begin
            // acc <- floor((digit * 2^F + acc) / radix)
            dctrl.start  = 1'b1;
            dctrl.steps  = step_type'(FRACTION_WIDTH);
            div_rem_init = rd_digit;
            div_dvd_init = work_type'(acc_ff) << FRAC_PAD;
            count_in     = count_ff - 1'b1;
            state_in     = ST_FOLD;
         end
         ST_FOLD: begin
            if (dstat.done) begin
               acc_in   = div_quo[FRACTION_WIDTH-1:0];
               state_in = (count_ff == '0) ? ST_DONE : ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || load_out;
      fraction_in  = load_out ? acc_ff : fraction_ff;
      bad_out_in   = load_out ? bad_ff : bad_out_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      radix_ff    <= radix_in;
      bad_ff      <= bad_in;
      acc_ff      <= acc_in;
      fraction_ff <= fraction_in;
      bad_out_ff  <= bad_out_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.fraction  = fraction_ff;
   assign rsp_chan.bad_radix = bad_out_ff;

   // checks
   `HRI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE), "not idle after reset")
   `HRI_ASSERT(a_ready_div_idle, clock, reset, req_chan.ready |-> !dstat.busy, "ready while dividing")
   `HRI_ASSERT(a_done_after_busy, clock, reset, dstat.done |-> $past(dstat.busy), "divider done without run")
   `HRI_ASSERT(a_count_range, clock, reset, count_ff <= digit_count_type'(DIGIT_DEPTH), "digit stack overflow")
   `HRI_ASSERT(a_bad_zero, clock, reset, (rsp_chan.valid && rsp_chan.bad_radix) |-> (rsp_chan.fraction == '0), "bad radix with nonzero fraction")

endmodule

`default_nettype wire
